// ===== design/signed_integer_to_radix_digits_top_defines.svh =====
// Assertion macros, clocked on clock and disabled during reset.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH

`define SIRD_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

`define SIRD_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`define SIRD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/sird_pkg.sv =====
`default_nettype none

package sird_pkg;

   localparam int MAX_RADIX   = 16;
   localparam int RADIX_W     = 5;
   localparam int DIGIT_W     = 4;
   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int STACK_DEPTH = 32;
   localparam int STACK_AW    = 5;
   localparam int CNT_W       = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CHAR_W-1:0] SIGN_CHAR = 8'h2D;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGITS_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGITS_HIGH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_CORR,
      ST_EMIT
   } state_type;

   function automatic logic [CHAR_W-1:0] digit_char(
      input logic [DIGIT_W-1:0]    idx,
      input logic [CSR_DATA_W-1:0] lo,
      input logic [CSR_DATA_W-1:0] hi
   );
      logic [CSR_DATA_W-1:0] word;
      word = idx[3] ? hi : lo;
      return word[{idx[2:0], 3'b000} +: CHAR_W];
   endfunction

   function automatic logic char_is_bad(input logic [CHAR_W-1:0] c);
      return c == 8'h2B || c == 8'h2D || c == 8'h0C || c == 8'h09 ||
             c == 8'h0A || c == 8'h0D || c == 8'h0B || c == 8'h20 ||
             c == 8'h00;
   endfunction

   // floor(2^32 / r); quotient estimate is low by at most one
   function automatic logic [VALUE_W-1:0] radix_recip(input logic [RADIX_W-1:0] r);
      logic [VALUE_W-1:0] m;
      case (r)
         5'd2:    m = 32'h8000_0000;
         5'd3:    m = 32'h5555_5555;
         5'd4:    m = 32'h4000_0000;
         5'd5:    m = 32'h3333_3333;
         5'd6:    m = 32'h2AAA_AAAA;
         5'd7:    m = 32'h2492_4924;
         5'd8:    m = 32'h2000_0000;
         5'd9:    m = 32'h1C71_C71C;
         5'd10:   m = 32'h1999_9999;
         5'd11:   m = 32'h1745_D174;
         5'd12:   m = 32'h1555_5555;
         5'd13:   m = 32'h13B1_3B13;
         5'd14:   m = 32'h1249_2492;
         5'd15:   m = 32'h1111_1111;
         5'd16:   m = 32'h1000_0000;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== design/sird_alpha_check.sv =====
`default_nettype none

module sird_alpha_check
   import sird_pkg::*;
(
   input  wire logic [RADIX_W-1:0]    radix,
   input  wire logic [CSR_DATA_W-1:0] digits_low,
   input  wire logic [CSR_DATA_W-1:0] digits_high,
   output logic                       alpha_ok
);

   logic [CHAR_W-1:0] chars [MAX_RADIX];
   logic              in_use [MAX_RADIX];
   logic              bad_any;
   logic              dup_any;
   logic              range_ok;

   always_comb begin
      bad_any = 1'b0;
      dup_any = 1'b0;
      for (int i = 0; i < MAX_RADIX; i++) begin
         chars[i]  = digit_char(DIGIT_W'(i), digits_low, digits_high);
         in_use[i] = RADIX_W'(i) < radix;
      end
      for (int i = 0; i < MAX_RADIX; i++) begin
         bad_any = bad_any | (in_use[i] & char_is_bad(chars[i]));
         for (int j = i + 1; j < MAX_RADIX; j++) begin
            dup_any = dup_any | (in_use[j] & (chars[j] == chars[i]));
         end
      end
      range_ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX));
      alpha_ok = range_ok & ~bad_any & ~dup_any;
   end

endmodule

`default_nettype wire

// ===== design/sird_divider.sv =====
`default_nettype none

module sird_divider
   import sird_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 mul_en,
   input  wire logic [VALUE_W-1:0]   mag,
   input  wire logic [RADIX_W-1:0]   radix,
   output logic      [VALUE_W-1:0]   quot,
   output logic      [DIGIT_W-1:0]   rem
);

   logic [2*VALUE_W-1:0]       product_ff;
   logic [2*VALUE_W-1:0]       product_in;
   logic [VALUE_W-1:0]         q_est;
   logic [VALUE_W+RADIX_W-1:0] qr;
   logic [VALUE_W-1:0]         rem_raw;
   logic [VALUE_W-1:0]         radix_ext;
   logic                       fix;

   // stage 1: reciprocal multiply
   assign product_in = {{VALUE_W{1'b0}}, mag} *
                       {{VALUE_W{1'b0}}, radix_recip(radix)};

   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= product_in;
      end
   end

   // stage 2: back-multiply and single correction step
   always_comb begin
      q_est     = product_ff[2*VALUE_W-1:VALUE_W];
      qr        = {{RADIX_W{1'b0}}, q_est} * {{VALUE_W{1'b0}}, radix};
      radix_ext = {{(VALUE_W-RADIX_W){1'b0}}, radix};
      rem_raw   = mag - qr[VALUE_W-1:0];
      fix       = rem_raw >= radix_ext;
      quot      = q_est + {{(VALUE_W-1){1'b0}}, fix};
      rem       = fix ? DIGIT_W'(rem_raw - radix_ext) : rem_raw[DIGIT_W-1:0];
   end

endmodule

`default_nettype wire

// ===== design/signed_integer_to_radix_digits_top.sv =====
// Signed integer to text in a configurable radix.
// csr_we/csr_index/csr_wdata write radix (0), digits_low (1) and
// digits_high (2); write only while the block is idle.
// req_*: one 32-bit signed value per transfer. rsp_*: one character per
// transfer, '-' first for a negative value, digits most significant
// first, rsp_tlast on the final character. An invalid alphabet accepts
// the value and returns nothing.
// Each digit passes through the shared reciprocal-multiply divider in ST_MUL
// (multiply), then ST_CORR (back-multiply and correct); the digit stack
// then gives one character per cycle when the receiver never stalls;
// at most 32 digits at radix 2, 10 at radix 10, 8 at radix 16.
// req_tready is high only in the idle state; the output register holds
// the last character while the next value is accepted.
// A stalled receiver freezes character emission; the divider never waits.
// Reset clears the CSRs (alphabet invalid), state and counters and empties the output.
`default_nettype none

`include "signed_integer_to_radix_digits_top_defines.svh"

module signed_integer_to_radix_digits_top
   import sird_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [VALUE_W-1:0]    req_tdata,   // [31:0] value
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [CHAR_W-1:0]     rsp_tdata,   // [7:0] character
   output logic                       rsp_tlast    // last
);

   logic [RADIX_W-1:0]    radix_ff;
   logic [CSR_DATA_W-1:0] digits_low_ff;
   logic [CSR_DATA_W-1:0] digits_high_ff;

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               sign_ff, sign_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [CHAR_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic               rsp_tlast_ff, rsp_tlast_in;

   logic [DIGIT_W-1:0] stack_ff [STACK_DEPTH];
   logic               push;
   logic [CNT_W-1:0]   cnt_dec;

   logic               alpha_ok;
   logic               mul_en;
   logic [VALUE_W-1:0] div_quot;
   logic [DIGIT_W-1:0] div_rem;
   logic               out_free;

   sird_alpha_check u_alpha (
      .radix       (radix_ff),
      .digits_low  (digits_low_ff),
      .digits_high (digits_high_ff),
      .alpha_ok    (alpha_ok)
   );

   sird_divider u_div (
      .clock  (clock),
      .mul_en (mul_en),
      .mag    (mag_ff),
      .radix  (radix_ff),
      .quot   (div_quot),
      .rem    (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= '0;
         digits_low_ff  <= '0;
         digits_high_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIX:       radix_ff       <= csr_wdata[RADIX_W-1:0];
            CSR_DIGITS_LOW:  digits_low_ff  <= csr_wdata;
            CSR_DIGITS_HIGH: digits_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         sign_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         sign_ff       <= sign_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      if (push) begin
         stack_ff[cnt_ff[STACK_AW-1:0]] <= div_rem;
      end
   end

   assign out_free = ~rsp_tvalid_ff | rsp_tready;
   assign cnt_dec  = cnt_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      mag_in        = mag_ff;
      cnt_in        = cnt_ff;
      sign_in       = sign_ff;
      push          = 1'b0;
      mul_en        = 1'b0;
      req_tready    = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && alpha_ok) begin
               mag_in   = req_tdata[VALUE_W-1] ? (~req_tdata + VALUE_W'(1)) : req_tdata;
               sign_in  = req_tdata[VALUE_W-1];
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_en   = 1'b1;
            state_in = ST_CORR;
         end
         ST_CORR: begin
            push     = 1'b1;
            mag_in   = div_quot;
            cnt_in   = cnt_ff + CNT_W'(1);
            state_in = (div_quot == '0) ? ST_EMIT : ST_MUL;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               if (sign_ff) begin
                  rsp_tdata_in = SIGN_CHAR;
                  rsp_tlast_in = 1'b0;
                  sign_in      = 1'b0;
               end else begin
                  rsp_tdata_in = digit_char(stack_ff[cnt_dec[STACK_AW-1:0]],
                                            digits_low_ff, digits_high_ff);
                  rsp_tlast_in = (cnt_ff == CNT_W'(1));
                  cnt_in       = cnt_dec;
                  if (cnt_ff == CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `SIRD_ASSERT_IMPLIES(a_rem_below_radix, state_ff == ST_CORR, RADIX_W'(div_rem) < radix_ff)
   `SIRD_ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= CNT_W'(STACK_DEPTH))
   `SIRD_ASSERT_ALWAYS(a_emit_nonempty, state_ff != ST_EMIT || cnt_ff != '0)
   `SIRD_ASSERT_NEXT(a_start_divide, req_tvalid && req_tready && alpha_ok, state_ff == ST_MUL)

endmodule

`default_nettype wire

// ===== tb/tb_signed_integer_to_radix_digits_top.sv =====
module tb_signed_integer_to_radix_digits_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sird_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int RANDOM_VALID   = 360;
   localparam int QUIET_FROM     = 300;

   localparam logic [CSR_IDX_W-1:0] CSR_UNKNOWN = 2'd3;
   localparam logic [CHAR_W-1:0] RESERVED_CHARS [9] = '{
      8'h2B, 8'h2D, 8'h0C, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h20, 8'h00
   };

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_beat_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [CHAR_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;

   logic [RADIX_W-1:0]    cfg_radix = '0;
   logic [CSR_DATA_W-1:0] cfg_lo    = '0;
   logic [CSR_DATA_W-1:0] cfg_hi    = '0;

   text_beat_type expected_chars[$];
   int            mismatch_count = 0;
   int            quiet_cycles   = 0;
   int            stall_left     = 0;
   bit            idle_on        = 1'b1;

   signed_integer_to_radix_digits_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] value
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] character
      .rsp_tlast  (rsp_tlast)    // last
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_reserved(input logic [CHAR_W-1:0] c);
      foreach (RESERVED_CHARS[k])
         if (c == RESERVED_CHARS[k]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [2*CSR_DATA_W-1:0] w;
      w = {cfg_hi, cfg_lo};
      return w[{d, 3'b000} +: CHAR_W];
   endfunction

   function automatic bit alphabet_valid();
      if (cfg_radix < 2 || cfg_radix > MAX_RADIX) return 1'b0;
      for (int i = 0; i < cfg_radix; i++) begin
         if (is_reserved(glyph(DIGIT_W'(i)))) return 1'b0;
         for (int j = i + 1; j < cfg_radix; j++)
            if (glyph(DIGIT_W'(j)) == glyph(DIGIT_W'(i))) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_text(input logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] base;
      logic [CHAR_W-1:0]  stack [32];
      int                 depth;
      depth = 0;
      base  = VALUE_W'(cfg_radix);
      if (!alphabet_valid()) return;
      mag = v;
      if (v[VALUE_W-1]) begin
         mag = -v;
         expected_chars.push_back('{ch: SIGN_CHAR, last: 1'b0});
      end
      do begin
         stack[depth] = glyph(DIGIT_W'(mag % base));
         mag = mag / base;
         depth++;
      end while (mag != 0 && depth < 32);
      for (int k = depth - 1; k >= 0; k--)
         expected_chars.push_back('{ch: stack[k], last: (k == 0)});
   endfunction

   function automatic logic [2*CSR_DATA_W-1:0] pack_glyphs(input string s);
      logic [2*CSR_DATA_W-1:0] w;
      w = '0;
      for (int k = 0; k < s.len() && k < MAX_RADIX; k++) w[8*k +: 8] = s[k];
      return w;
   endfunction

   function automatic logic [2*CSR_DATA_W-1:0] rand_glyphs(input int r);
      logic [2*CSR_DATA_W-1:0] w;
      logic [CHAR_W-1:0]       c;
      bit                      clash;
      for (int k = 0; k < MAX_RADIX; k++) w[8*k +: 8] = CHAR_W'($urandom);
      for (int k = 0; k < r; k++) begin
         do begin
            c = CHAR_W'($urandom);
            clash = is_reserved(c);
            for (int j = 0; j < k; j++)
               if (w[8*j +: 8] == c) clash = 1'b1;
         end while (clash);
         w[8*k +: 8] = c;
      end
      return w;
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom_range(0, 40);
         1: v = $urandom >> $urandom_range(0, 31);
         2: begin
            case ($urandom_range(0, 3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = '1;
               default: v = '0;
            endcase
         end
         default: v = $urandom;
      endcase
      if ($urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_alphabet(input logic [CSR_DATA_W-1:0] radix_word,
                                input logic [2*CSR_DATA_W-1:0] chars);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_RADIX;
      csr_wdata <= radix_word;
      @(posedge clock);
      csr_index <= CSR_DIGITS_LOW;
      csr_wdata <= chars[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_DIGITS_HIGH;
      csr_wdata <= chars[2*CSR_DATA_W-1:CSR_DATA_W];
      @(posedge clock);
      if ($urandom_range(0, 3) == 0) begin
         csr_index <= CSR_UNKNOWN;
         csr_wdata <= {$urandom, $urandom};
         @(posedge clock);
      end
      csr_we    <= 1'b0;
      cfg_radix = radix_word[RADIX_W-1:0];
      cfg_lo    = chars[CSR_DATA_W-1:0];
      cfg_hi    = chars[2*CSR_DATA_W-1:CSR_DATA_W];
   endtask

   task automatic send_value(input logic [VALUE_W-1:0] v);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      predict_text(v);
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 9) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      text_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transfer: ch %02h last %0b", rsp_tdata, rsp_tlast);
         end else begin
            want = expected_chars.pop_front();
            if (want.ch !== rsp_tdata || want.last !== rsp_tlast) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected ch %02h last %0b, got ch %02h last %0b",
                           want.ch, want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic test_after_reset();
      send_value(32'd12345);
   endtask

   task automatic test_decimal();
      load_alphabet(64'd10, pack_glyphs("0123456789"));
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
   endtask

   task automatic test_binary_extremes();
      load_alphabet(64'd2, pack_glyphs("01"));
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'd0);
   endtask

   task automatic test_hex_full_alphabet();
      load_alphabet(64'd16, pack_glyphs("0123456789ABCDEF"));
      send_value(32'h7EDC_BA98);
      send_value(32'hFFFF_FFF1);
      send_value(32'h89AB_CDEF);
   endtask

   task automatic test_invalid_alphabets();
      logic [2*CSR_DATA_W-1:0] chars;
      foreach (RESERVED_CHARS[k]) begin
         chars = pack_glyphs("0123456789ABCDEF");
         chars[8*((k * 7) % MAX_RADIX) +: 8] = RESERVED_CHARS[k];
         load_alphabet(64'd16, chars);
         send_value(32'hFFFF_CFC7);
      end
      load_alphabet(64'd1, pack_glyphs("0123456789ABCDEF"));
      send_value(32'd7);
      load_alphabet(64'd17, pack_glyphs("0123456789ABCDEF"));
      send_value(32'd7);
      load_alphabet({32'hA5A5_A5A5, 32'h0000_001F}, pack_glyphs("0123456789ABCDEF"));
      send_value(32'd7);
      load_alphabet(64'd10, pack_glyphs("0123456780"));
      send_value(32'd99);
   endtask

   task automatic test_unused_bytes();
      logic [2*CSR_DATA_W-1:0] chars;
      chars = pack_glyphs("012--  ++1");
      load_alphabet({32'hFFFF_FFFF, 32'hFFFF_FFE3}, chars);
      send_value(32'hFFFF_FFF9);
   endtask

   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0]   radix_word;
      logic [CSR_DATA_W-1:0]   noise;
      logic [2*CSR_DATA_W-1:0] chars;
      int                      r;
      int                      p;
      int                      kind;
      int                      valid_items;
      valid_items = 0;
      while (valid_items < RANDOM_VALID) begin
         idle_on = (valid_items < QUIET_FROM);
         case ($urandom_range(0, 3))
            0:       r = 2;
            1:       r = 16;
            default: r = $urandom_range(2, 16);
         endcase
         chars      = rand_glyphs(r);
         radix_word = CSR_DATA_W'(r);
         if ($urandom_range(0, 3) == 0) begin
            noise = {$urandom, $urandom};
            radix_word[CSR_DATA_W-1:RADIX_W] = noise[CSR_DATA_W-1:RADIX_W];
         end
         kind = $urandom_range(0, 9);
         case (kind)
            0: radix_word[RADIX_W-1:0] = ($urandom_range(0, 1) == 1) ?
                  RADIX_W'($urandom_range(0, 1)) : RADIX_W'($urandom_range(17, 31));
            1: chars[8*$urandom_range(0, r - 1) +: 8] =
                  RESERVED_CHARS[$urandom_range(0, 8)];
            2: begin
               p = $urandom_range(1, r - 1);
               chars[8*p +: 8] = chars[8*$urandom_range(0, p - 1) +: 8];
            end
            default: ;
         endcase
         load_alphabet(radix_word, chars);
         if (alphabet_valid()) begin
            repeat (30) send_value(rand_value());
            valid_items += 30;
         end else begin
            repeat (5) send_value(rand_value());
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_decimal();
      test_binary_extremes();
      test_hex_full_alphabet();
      test_invalid_alphabets();
      test_unused_bytes();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/sird_pkg.sv
design/sird_alpha_check.sv
design/sird_divider.sv
design/signed_integer_to_radix_digits_top.sv
tb/tb_signed_integer_to_radix_digits_top.sv
